// ===== hw/rtl/fjp_pkg.sv =====
// ----------------------------------------------------------------------------
// fjp_pkg
// Shared types, codes and character classes for the flat JSON array parser.
// ----------------------------------------------------------------------------
package fjp_pkg;

  localparam int NumWidth = 63;

  localparam logic [NumWidth-1:0] NUM_MAX = {NumWidth{1'b1}};

  // Parser states.
  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_ARR_FIRST = 4'd1,
    ST_ARR_OBJ   = 4'd2,
    ST_ARR_AFTER = 4'd3,
    ST_OBJ_FIRST = 4'd4,
    ST_KEY_OPEN  = 4'd5,
    ST_KEY       = 4'd6,
    ST_COLON     = 4'd7,
    ST_VALUE     = 4'd8,
    ST_STR       = 4'd9,
    ST_NUM       = 4'd10,
    ST_OBJ_AFTER = 4'd11,
    ST_DONE      = 4'd12,
    ST_ERR       = 4'd13
  } parse_state_t;

  // Event codes.
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_ARR_OPEN  = 4'd1;
  localparam logic [3:0] EV_OBJ_OPEN  = 4'd2;
  localparam logic [3:0] EV_KEY_BYTE  = 4'd3;
  localparam logic [3:0] EV_KEY_END   = 4'd4;
  localparam logic [3:0] EV_STR_BYTE  = 4'd5;
  localparam logic [3:0] EV_STR_END   = 4'd6;
  localparam logic [3:0] EV_OBJ_CLOSE = 4'd7;
  localparam logic [3:0] EV_ARR_CLOSE = 4'd8;
  localparam logic [3:0] EV_ERROR     = 4'd9;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_NUM_EXP    = 3'd2;
  localparam logic [2:0] ERR_UNTERM     = 3'd3;
  localparam logic [2:0] ERR_EARLY_END  = 3'd4;
  localparam logic [2:0] ERR_EMPTY      = 3'd5;

  // Characters of the grammar.
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // One result as it leaves the parser.
  typedef struct packed {
    logic [3:0]          event_res;
    logic [7:0]          char_byte;
    logic                number_done;
    logic [NumWidth-1:0] number_value;
    logic [2:0]          error_code;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

// ===== hw/rtl/fjp_num_acc.sv =====
// ----------------------------------------------------------------------------
// fjp_num_acc
// Saturating decimal accumulate: acc * 10 + digit, clamped at 2^63-1.
// ----------------------------------------------------------------------------
module fjp_num_acc (
  input  logic [fjp_pkg::NumWidth-1:0] acc,
  input  logic [3:0]                   digit,
  output logic [fjp_pkg::NumWidth-1:0] acc_next
);
  import fjp_pkg::*;

  logic [NumWidth+3:0] wide;

  // Times ten as two shifted copies; the top four bits flag overflow.
  assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NumWidth{1'b0}}, digit};

  assign acc_next = (|wide[NumWidth+3:NumWidth]) ? NUM_MAX : wide[NumWidth-1:0];

endmodule

// ===== hw/rtl/fjp_step.sv =====
// ----------------------------------------------------------------------------
// fjp_step
// Next-state and result logic for one byte of the JSON text.
// ----------------------------------------------------------------------------
module fjp_step (
  input  fjp_pkg::parse_state_t          state,
  input  logic [fjp_pkg::NumWidth-1:0]   acc,
  input  logic [2:0]                     held_error,
  input  logic [7:0]                     data_byte,
  input  logic                           end_of_data,
  output fjp_pkg::parse_state_t          state_next,
  output logic [fjp_pkg::NumWidth-1:0]   acc_next,
  output logic [2:0]                     held_error_next,
  output fjp_pkg::result_t               res
);
  import fjp_pkg::*;

  logic [NumWidth-1:0] acc_sum;
  parse_state_t        st;
  logic [3:0]          ev;
  logic [7:0]          ch;
  logic [2:0]          err;
  logic                nd;
  logic [NumWidth-1:0] nv;

  fjp_num_acc u_num_acc (
    .acc      (acc),
    .digit    (data_byte[3:0]),
    .acc_next (acc_sum)
  );

  always_comb begin
    st              = state;
    ev              = EV_NONE;
    ch              = 8'h00;
    err             = ERR_NONE;
    nd              = 1'b0;
    nv              = '0;
    acc_next        = acc;
    held_error_next = held_error;
    state_next      = state;
    res             = '0;

    if (state == ST_ERR) begin
      res.event_res  = EV_ERROR;
      res.error_code = held_error;
    end else begin
      // A number ends on its first non-digit, which is then parsed as usual.
      if (st == ST_NUM) begin
        if (is_digit(data_byte)) begin
          acc_next = acc_sum;
        end else begin
          nd = 1'b1;
          nv = acc;
          st = ST_OBJ_AFTER;
        end
      end

      case (st)
        ST_START: begin
          if (data_byte == CH_LBRACK) begin
            ev = EV_ARR_OPEN;
            st = ST_ARR_FIRST;
          end else if (!is_ws(data_byte)) begin
            err = ERR_UNEXPECTED;
          end
        end
        ST_ARR_FIRST: begin
          if (data_byte == CH_RBRACK) begin
            ev = EV_ARR_CLOSE;
            st = ST_DONE;
          end else if (data_byte == CH_LBRACE) begin
            ev = EV_OBJ_OPEN;
            st = ST_OBJ_FIRST;
          end else if (is_ws(data_byte)) begin
            st = ST_ARR_OBJ;
          end else begin
            err = ERR_UNEXPECTED;
          end
        end
        ST_ARR_OBJ: begin
          if (data_byte == CH_LBRACE) begin
            ev = EV_OBJ_OPEN;
            st = ST_OBJ_FIRST;
          end else if (!is_ws(data_byte)) begin
            err = ERR_UNEXPECTED;
          end
        end
        ST_ARR_AFTER: begin
          if (data_byte == CH_RBRACK) begin
            ev = EV_ARR_CLOSE;
            st = ST_DONE;
          end else if (data_byte == CH_COMMA) begin
            st = ST_ARR_OBJ;
          end else if (!is_ws(data_byte)) begin
            err = ERR_UNEXPECTED;
          end
        end
        ST_OBJ_FIRST: begin
          if (data_byte == CH_RBRACE) begin
            ev = EV_OBJ_CLOSE;
            st = ST_ARR_AFTER;
          end else if (data_byte == CH_QUOTE) begin
            st = ST_KEY;
          end else if (is_ws(data_byte)) begin
            st = ST_KEY_OPEN;
          end else begin
            err = ERR_UNEXPECTED;
          end
        end
        ST_KEY_OPEN: begin
          if (data_byte == CH_QUOTE) begin
            st = ST_KEY;
          end else if (!is_ws(data_byte)) begin
            err = ERR_UNEXPECTED;
          end
        end
        ST_KEY: begin
          if (data_byte == CH_QUOTE) begin
            ev = EV_KEY_END;
            st = ST_COLON;
          end else begin
            ev = EV_KEY_BYTE;
            ch = data_byte;
          end
        end
        ST_COLON: begin
          if (data_byte == CH_COLON) begin
            st = ST_VALUE;
          end else if (!is_ws(data_byte)) begin
            err = ERR_UNEXPECTED;
          end
        end
        ST_VALUE: begin
          if (data_byte == CH_QUOTE) begin
            st = ST_STR;
          end else if (is_digit(data_byte)) begin
            acc_next = {{(NumWidth-4){1'b0}}, data_byte[3:0]};
            st       = ST_NUM;
          end else if (!is_ws(data_byte)) begin
            err = ERR_NUM_EXP;
          end
        end
        ST_STR: begin
          if (data_byte == CH_QUOTE) begin
            ev = EV_STR_END;
            st = ST_OBJ_AFTER;
          end else begin
            ev = EV_STR_BYTE;
            ch = data_byte;
          end
        end
        ST_OBJ_AFTER: begin
          if (data_byte == CH_RBRACE) begin
            ev = EV_OBJ_CLOSE;
            st = ST_ARR_AFTER;
          end else if (data_byte == CH_COMMA) begin
            st = ST_KEY_OPEN;
          end else if (!is_ws(data_byte)) begin
            err = ERR_UNEXPECTED;
          end
        end
        ST_NUM, ST_DONE: begin
          st = st;
        end
        default: begin
          st = ST_START;
        end
      endcase

      if ((err == ERR_NONE) && end_of_data && (st != ST_DONE)) begin
        if ((st == ST_KEY) || (st == ST_STR)) begin
          err = ERR_UNTERM;
        end else if (st == ST_START) begin
          err = ERR_EMPTY;
        end else begin
          err = ERR_EARLY_END;
        end
      end

      if (err != ERR_NONE) begin
        held_error_next = err;
        state_next      = ST_ERR;
        res.event_res   = EV_ERROR;
        res.error_code  = err;
      end else begin
        state_next       = st;
        res.event_res    = ev;
        res.char_byte    = ch;
        res.number_done  = nd;
        res.number_value = nv;
      end
    end
  end

endmodule

// ===== hw/rtl/flat_json_array_parser.sv =====
// ----------------------------------------------------------------------------
// flat_json_array_parser
// Byte-serial parser for a JSON array of flat objects with string or
// unsigned integer values.
// ----------------------------------------------------------------------------
// The parser takes one byte of JSON text per request and returns exactly one
// result request per byte, in order, at a sustained rate of one byte per
// clock: each byte is parsed against the registered parser state and the
// result is captured in an output register. The next byte is taken in the
// following cycle as long as the consumer drains the previous result in
// that same cycle; while a result waits unaccepted, input requests are held
// off. The critical path is the 67-bit shift-and-add that folds a decimal
// digit into the saturating number accumulator. A result carries a structural
// event, a key or string byte, or an error code; a completed integer is
// reported with the number_done flag on the byte that ends it, alongside
// that byte's own event unless that byte raises an error. Once an error is
// reported, every further byte repeats it until reset, and bytes that follow
// the closing bracket produce empty results.
module flat_json_array_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [7:0]                   data_byte,
  input  logic                         end_of_data,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [3:0]                   event_res,
  output logic [7:0]                   char_byte,
  output logic                         number_done,
  output logic [fjp_pkg::NumWidth-1:0] number_value,
  output logic [2:0]                   error_code
);
  import fjp_pkg::*;

  // Parser state carried from one byte to the next.
  parse_state_t        state;
  parse_state_t        state_next;
  logic [NumWidth-1:0] acc;
  logic [NumWidth-1:0] acc_next;
  logic [2:0]          held_error;
  logic [2:0]          held_error_next;

  // Result computed for the byte on the input and the registered copy.
  result_t             res_next;
  result_t             res;

  logic                accept;

  // A byte can be taken whenever the output register is empty or is being
  // drained in this same cycle.
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  fjp_step u_step (
    .state           (state),
    .acc             (acc),
    .held_error      (held_error),
    .data_byte       (data_byte),
    .end_of_data     (end_of_data),
    .state_next      (state_next),
    .acc_next        (acc_next),
    .held_error_next (held_error_next),
    .res             (res_next)
  );

  // The parser state advances only when a byte is actually accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_START;
      acc        <= '0;
      held_error <= ERR_NONE;
    end else if (accept) begin
      state      <= state_next;
      acc        <= acc_next;
      held_error <= held_error_next;
    end
  end

  // Output register: loaded on accept, emptied when the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // The payload needs no reset; it is only looked at while result_valid is set.
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign event_res    = res.event_res;
  assign char_byte    = res.char_byte;
  assign number_done  = res.number_done;
  assign number_value = res.number_value;
  assign error_code   = res.error_code;

endmodule
